// ===== src/tlma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlma_pkg
// Shared constants, breakpoint tables and types of the table linearizer with
// moving-average smoothing.
// ----------------------------------------------------------------------------
package tlma_pkg;

  localparam int TABLE_POINTS = 51;
  localparam int SAMPLE_BITS  = 12;
  localparam int WINDOW_DEF   = 10;
  localparam int SAMPLE_W     = 12;
  localparam int TEMP_W       = 15;
  localparam int IDX_W        = $clog2(TABLE_POINTS);

  // breakpoint converter codes, rising
  localparam logic [SAMPLE_BITS-1:0] BP_ADC [TABLE_POINTS] = '{
    12'd541,  12'd561,  12'd601,  12'd628,  12'd707,  12'd743,  12'd777,
    12'd798,  12'd860,  12'd888,  12'd943,  12'd976,  12'd1008, 12'd1044,
    12'd1076, 12'd1123, 12'd1152, 12'd1194, 12'd1198, 12'd1235, 12'd1270,
    12'd1312, 12'd1384, 12'd1422, 12'd1462, 12'd1493, 12'd1507, 12'd1555,
    12'd1600, 12'd1646, 12'd1677, 12'd1718, 12'd1747, 12'd1793, 12'd1834,
    12'd1871, 12'd1905, 12'd1947, 12'd1982, 12'd2005, 12'd2055, 12'd2089,
    12'd2119, 12'd2164, 12'd2199, 12'd2231, 12'd2283, 12'd2337, 12'd2353,
    12'd2389, 12'd2433
  };

  // breakpoint temperatures in 1/256 degC: 18.5 C, then 20.0 .. 69.0 C
  localparam logic [TEMP_W-1:0] BP_TEMP [TABLE_POINTS] = '{
    15'd4736,  15'd5120,  15'd5376,  15'd5632,  15'd5888,  15'd6144,
    15'd6400,  15'd6656,  15'd6912,  15'd7168,  15'd7424,  15'd7680,
    15'd7936,  15'd8192,  15'd8448,  15'd8704,  15'd8960,  15'd9216,
    15'd9472,  15'd9728,  15'd9984,  15'd10240, 15'd10496, 15'd10752,
    15'd11008, 15'd11264, 15'd11520, 15'd11776, 15'd12032, 15'd12288,
    15'd12544, 15'd12800, 15'd13056, 15'd13312, 15'd13568, 15'd13824,
    15'd14080, 15'd14336, 15'd14592, 15'd14848, 15'd15104, 15'd15360,
    15'd15616, 15'd15872, 15'd16128, 15'd16384, 15'd16640, 15'd16896,
    15'd17152, 15'd17408, 15'd17664
  };

  localparam logic [TEMP_W-1:0] TEMP_MIN = BP_TEMP[0];
  localparam logic [TEMP_W-1:0] TEMP_MAX = BP_TEMP[TABLE_POINTS-1];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_INTERP,
    ST_IDIV,
    ST_ACC,
    ST_MDIV,
    ST_OUT
  } tlma_state_t;

endpackage

// ===== src/tlma_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlma_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 10,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/tlma_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlma_div
// Restoring unsigned divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module tlma_div #(
  parameter int NW = 27,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   shifted;
  logic [DW+1:0] diff;

  assign shifted = {rem, quo[NW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      dvs <= den;
      rem <= '0;
    end else if (busy) begin
      if (diff[DW+1]) begin
        rem <= shifted[DW-1:0];
        quo <= {quo[NW-2:0], 1'b0};
      end else begin
        rem <= diff[DW-1:0];
        quo <= {quo[NW-2:0], 1'b1};
      end
    end
  end

endmodule

// ===== src/table_linearize_and_moving_average.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_linearize_and_moving_average
// Converter reading to temperature by piecewise-linear table interpolation,
// followed by a moving average over the last WINDOW temperatures (over all so far until the ring fills).
// ----------------------------------------------------------------------------
// Usage:
//   input channel  in_valid / in_ready carries sensor_sample, one beat per
//   reading. Output channel out_valid / out_ready carries instant_temp and
//   smoothed_temp, one beat per reading, in 1/256 degC.
//   One reading is worked on at a time: in_ready is high only while idle.
//   NW is the dividend width of the shared bit-serial divider (27 bits by
//   default). A reading is searched, then divided for the slope, then
//   divided for the mean; a clamped reading skips the search and the
//   first division, a flat segment skips the first division. The divider
//   runs at most twice per reading and sets the throughput.
//   The history lives in a WINDOW-entry RAM; a running sum is kept by
//   reading back the entry about to be overwritten once the ring is full.
//   Reset clears the ring pointer, the fill flag and the sum; no clearing
//   pass is needed since unwritten entries are never used.
//   A finished result sits in the output register until taken; while the
//   receiver stalls the next reading can be accepted and worked on, and
//   it waits in its last state until the output register is free.
// ----------------------------------------------------------------------------
module table_linearize_and_moving_average #(
  parameter int WINDOW = tlma_pkg::WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tlma_pkg::SAMPLE_W-1:0] sensor_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tlma_pkg::TEMP_W-1:0] instant_temp,
  output logic [tlma_pkg::TEMP_W-1:0] smoothed_temp
);

  import tlma_pkg::*;

  localparam int AW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = TEMP_W + CNT_W;
  localparam int MUL_W  = TEMP_W + SAMPLE_BITS;
  localparam int DIV_NW = (MUL_W > SUM_W) ? MUL_W : SUM_W;
  localparam int DIV_DW = (SAMPLE_BITS > CNT_W) ? SAMPLE_BITS : CNT_W;

  tlma_state_t state, state_next;

  logic [SAMPLE_BITS-1:0] samp;
  logic [SAMPLE_BITS-1:0] in_samp;
  logic [IDX_W-1:0]       lo;
  logic [IDX_W-1:0]       hi;
  logic [IDX_W:0]         mid_sum;
  logic [IDX_W-1:0]       mid;
  logic [IDX_W-1:0]       seg_lo;
  logic [TEMP_W-1:0]      temp;
  logic [TEMP_W-1:0]      base;
  logic [SUM_W-1:0]       sum;
  logic [SUM_W-1:0]       sum_next;
  logic [AW-1:0]          wp;
  logic [AW-1:0]          wp_next;
  logic                   full;
  logic                   full_next;
  logic [CNT_W-1:0]       count_next;
  logic                   wrap;

  logic [SAMPLE_BITS-1:0] s1, s2;
  logic [TEMP_W-1:0]      t1, t2;
  logic                   flat_seg;
  logic [MUL_W-1:0]       slope_prod;

  logic                   accept;
  logic                   out_load;
  logic                   clamp_lo, clamp_hi;

  logic                   div_start;
  logic [DIV_NW-1:0]      div_num;
  logic [DIV_DW-1:0]      div_den;
  logic                   div_done;
  logic [DIV_NW-1:0]      div_quo;

  logic [TEMP_W-1:0]      ring_old;

  assign in_samp  = sensor_sample[SAMPLE_BITS-1:0];
  assign accept   = in_valid && in_ready;
  assign clamp_lo = in_samp <= BP_ADC[0];
  assign clamp_hi = in_samp >= BP_ADC[TABLE_POINTS-1];

  // binary search for the first breakpoint at or above the sample
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[IDX_W:1];

  assign seg_lo     = lo - 1'b1;
  assign s1         = BP_ADC[seg_lo];
  assign s2         = BP_ADC[lo];
  assign t1         = BP_TEMP[seg_lo];
  assign t2         = BP_TEMP[lo];
  assign flat_seg   = (s2 <= s1) || (t2 < t1);
  assign slope_prod = (MUL_W'(t2 - t1)) * (MUL_W'(samp - s1));

  // running sum: drop the oldest entry once the ring has filled
  assign wrap       = (wp == AW'(WINDOW - 1));
  assign wp_next    = wrap ? '0 : wp + 1'b1;
  assign full_next  = full || wrap;
  assign sum_next   = sum + SUM_W'(temp) - (full ? SUM_W'(ring_old) : '0);
  assign count_next = full_next ? CNT_W'(WINDOW) : (CNT_W'(wp) + 1'b1);

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    div_start  = 1'b0;
    div_num    = DIV_NW'(slope_prod);
    div_den    = DIV_DW'(s2 - s1);
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (clamp_lo || clamp_hi) ? ST_ACC : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (lo == hi) begin
          state_next = ST_INTERP;
        end
      end
      ST_INTERP: begin
        if (flat_seg) begin
          state_next = ST_ACC;
        end else begin
          div_start  = 1'b1;
          state_next = ST_IDIV;
        end
      end
      ST_IDIV: begin
        if (div_done) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        div_start  = 1'b1;
        div_num    = DIV_NW'(sum_next);
        div_den    = DIV_DW'(count_next);
        state_next = ST_MDIV;
      end
      ST_MDIV: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      full      <= 1'b0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_ACC) begin
        wp   <= wp_next;
        full <= full_next;
        sum  <= sum_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      samp <= in_samp;
      lo   <= IDX_W'(1);
      hi   <= IDX_W'(TABLE_POINTS - 1);
      temp <= clamp_lo ? TEMP_MIN : TEMP_MAX;
    end
    if (state == ST_SEARCH && lo != hi) begin
      if (BP_ADC[mid] >= samp) begin
        hi <= mid;
      end else begin
        lo <= mid + 1'b1;
      end
    end
    if (state == ST_INTERP) begin
      base <= t1;
      temp <= t1;
    end
    if (state == ST_IDIV && div_done) begin
      temp <= base + div_quo[TEMP_W-1:0];
    end
    if (out_load) begin
      instant_temp  <= temp;
      smoothed_temp <= div_quo[TEMP_W-1:0];
    end
  end

  tlma_div #(
    .NW (DIV_NW),
    .DW (DIV_DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // oldest entry is fetched at accept and used in the accumulate step
  tlma_ram #(
    .WIDTH (TEMP_W),
    .DEPTH (WINDOW),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (state == ST_ACC),
    .waddr (wp),
    .wdata (temp),
    .re    (accept),
    .raddr (wp),
    .rdata (ring_old)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second reading accepted while one is in progress");

  a_full_sticks: assert property (@(posedge clk) disable iff (rst)
    full |=> full)
    else $error("fill flag dropped after the ring filled");

  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    wp <= AW'(WINDOW - 1))
    else $error("ring pointer beyond window");

  a_instant_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (instant_temp >= TEMP_MIN) && (instant_temp <= TEMP_MAX))
    else $error("interpolated temperature outside table range");

  a_smoothed_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (smoothed_temp >= TEMP_MIN) && (smoothed_temp <= TEMP_MAX))
    else $error("mean temperature outside table range");

endmodule
